### src/nr_transport_block_size_unit_defines.svh
// Assertion macros shared by the transport block size unit.
// Depends on nothing; files that assert include it by bare name.
`ifndef NR_TRANSPORT_BLOCK_SIZE_UNIT_DEFINES_SVH
`define NR_TRANSPORT_BLOCK_SIZE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NR_TBS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NR_TBS_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define NR_TBS_ASSERT(label, clk, rst, prop, msg)
`define NR_TBS_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### src/nr_tbs_pkg.sv
// Package of the transport block size unit: widths, size table, command
// and status structs. Depends on nothing.
package nr_tbs_pkg;

   localparam int TABLE_ENTRIES   = 93;
   localparam int MAX_BLOCKS      = 275;
   localparam int PUBLISHED_COUNT = 93;
   localparam int IDX_W           = $clog2(TABLE_ENTRIES);
   localparam int PUB_W           = $clog2(PUBLISHED_COUNT);
   localparam int PROD_W          = 34;
   localparam int NINFO_W         = 23;
   localparam int Q_W             = 24;
   localparam int DIV_W           = 25;
   localparam int DIV_STEPS       = DIV_W;
   localparam int DCNT_W          = $clog2(DIV_STEPS + 1);
   localparam int C_W             = 13;
   localparam int OUT_W           = 21;
   localparam int LG_W            = 5;
   localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
   localparam logic [11:0] SMALL_LIMIT = 12'd3824;

   localparam logic [11:0] PUBLISHED [0:PUBLISHED_COUNT-1] = '{
      12'd24, 12'd32, 12'd40, 12'd48, 12'd56, 12'd64, 12'd72, 12'd80, 12'd88, 12'd96,
      12'd104, 12'd112, 12'd120, 12'd128, 12'd136, 12'd144, 12'd152, 12'd160, 12'd168,
      12'd176, 12'd184, 12'd192, 12'd208, 12'd224, 12'd240, 12'd256, 12'd272, 12'd288,
      12'd304, 12'd320, 12'd336, 12'd352, 12'd368, 12'd384, 12'd408, 12'd432, 12'd456,
      12'd480, 12'd504, 12'd528, 12'd552, 12'd576, 12'd608, 12'd640, 12'd672, 12'd704,
      12'd736, 12'd768, 12'd808, 12'd848, 12'd888, 12'd928, 12'd984, 12'd1032, 12'd1064,
      12'd1128, 12'd1160, 12'd1192, 12'd1224, 12'd1256, 12'd1288, 12'd1320, 12'd1352,
      12'd1416, 12'd1480, 12'd1544, 12'd1608, 12'd1672, 12'd1736, 12'd1800, 12'd1864,
      12'd1928, 12'd2024, 12'd2088, 12'd2152, 12'd2216, 12'd2280, 12'd2408, 12'd2472,
      12'd2536, 12'd2600, 12'd2664, 12'd2728, 12'd2792, 12'd2856, 12'd2976, 12'd3104,
      12'd3240, 12'd3368, 12'd3496, 12'd3624, 12'd3752, 12'd3824
   };

   function automatic logic [11:0] size_entry(input logic [IDX_W-1:0] idx);
      logic [11:0] val;
      val = SMALL_LIMIT;
      if (int'(idx) < PUBLISHED_COUNT) begin
         val = PUBLISHED[PUB_W'(idx)];
      end
      return val;
   endfunction

   typedef struct packed {
      logic load;
      logic mul;
      logic srch_init;
      logic srch_step;
      logic log_init;
      logic log_step;
      logic quant;
      logic div1_start;
      logic div2_start;
      logic div_step;
      logic prod;
      logic res_zero;
      logic res_small;
      logic res_plain;
      logic res_seg;
      logic out_load;
   } nr_tbs_cmd_type;

   typedef struct packed {
      logic mul_last;
      logic zero;
      logic fits_rom;
      logic seg;
      logic log_done;
      logic srch_done;
      logic div_done;
      logic out_free;
   } nr_tbs_status_type;

endpackage

### src/nr_tbs_datapath.sv
// Datapath of the transport block size unit: multiplier, log search,
// quantizer, table search, restoring divider, result register.
// Depends on nr_tbs_pkg and the assertion macro header.
`include "nr_transport_block_size_unit_defines.svh"
module nr_tbs_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  nr_tbs_pkg::nr_tbs_cmd_type    cmd,
   output nr_tbs_pkg::nr_tbs_status_type st,
   input  logic [8:0]                    req_num_blocks,
   input  logic [3:0]                    req_symbols_per_slot,
   input  logic [3:0]                    req_bits_per_symbol,
   input  logic [10:0]                   req_rate_units,
   input  logic [2:0]                    req_layer_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [20:0]                   rsp_block_size_bits
);

   logic [8:0]  blocks_ff, blocks_in;
   logic [3:0]  qm_ff, qm_in;
   logic [10:0] rate_ff, rate_in;
   logic [2:0]  layers_ff, layers_in;
   logic [nr_tbs_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [1:0]  mstep_ff, mstep_in;
   logic [nr_tbs_pkg::IDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [nr_tbs_pkg::NINFO_W-1:0] t_ff, t_in;
   logic [nr_tbs_pkg::LG_W-1:0] lg_ff, lg_in;
   logic [nr_tbs_pkg::Q_W-1:0] q_ff, q_in;
   logic [nr_tbs_pkg::DIV_W:0] rem_ff, rem_in;
   logic [nr_tbs_pkg::DIV_W-1:0] quo_ff, quo_in, dvs_ff, dvs_in;
   logic [nr_tbs_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [nr_tbs_pkg::C_W-1:0] c_ff, c_in;
   logic [nr_tbs_pkg::C_W+nr_tbs_pkg::DIV_W-1:0] ck_ff, ck_in;
   logic [20:0] res_ff, res_in;
   logic [20:0] out_ff, out_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [7:0]  re;
   logic [8:0]  blk_sat;
   logic [10:0] mul_b;
   logic [nr_tbs_pkg::NINFO_W-1:0] ninfo, dval;
   logic [11:0] q_small, ninfo12;
   logic [nr_tbs_pkg::IDX_W:0] mid_sum;
   logic [nr_tbs_pkg::IDX_W-1:0] mid;
   logic [11:0] mid_val;
   logic [nr_tbs_pkg::LG_W-1:0] nsh;
   logic [nr_tbs_pkg::Q_W-1:0] q_round, half;
   logic [13:0] limit;
   logic [nr_tbs_pkg::DIV_W:0] r2;
   logic [nr_tbs_pkg::Q_W:0] plain;
   logic [28:0] seg_tbs;

   always_comb begin
      re      = (req_symbols_per_slot >= 4'd13) ? 8'd156 : 8'(req_symbols_per_slot) * 8'd12;
      blk_sat = (req_num_blocks > 9'(nr_tbs_pkg::MAX_BLOCKS)) ?
                9'(nr_tbs_pkg::MAX_BLOCKS) : req_num_blocks;
      case (mstep_ff)
         2'd0:    mul_b = 11'(blocks_ff);
         2'd1:    mul_b = rate_ff;
         2'd2:    mul_b = 11'(qm_ff);
         default: mul_b = 11'(layers_ff);
      endcase
      ninfo   = prod_ff[nr_tbs_pkg::PROD_W-1:11];
      ninfo12 = ninfo[11:0];
      // quantize small sizes: step 8 below 1024, then 16 and 32
      if (ninfo12 >= 12'd2048) begin
         q_small = ninfo12 & ~12'd31;
      end else if (ninfo12 >= 12'd1024) begin
         q_small = ninfo12 & ~12'd15;
      end else begin
         q_small = ninfo12 & ~12'd7;
      end
      if (q_small < 12'd24) begin
         q_small = 12'd24;
      end
      mid_sum = (nr_tbs_pkg::IDX_W+1)'(lo_ff) + (nr_tbs_pkg::IDX_W+1)'(hi_ff);
      mid     = mid_sum[nr_tbs_pkg::IDX_W:1];
      mid_val = nr_tbs_pkg::size_entry(mid);
      dval    = ninfo - nr_tbs_pkg::NINFO_W'(24);
      nsh     = lg_ff - nr_tbs_pkg::LG_W'(5);
      half    = nr_tbs_pkg::Q_W'(1) << (nsh - nr_tbs_pkg::LG_W'(1));
      q_round = ((nr_tbs_pkg::Q_W'(dval) + half) >> nsh) << nsh;
      if (q_round < nr_tbs_pkg::Q_W'(3840)) begin
         q_round = nr_tbs_pkg::Q_W'(3840);
      end
      limit   = (rate_ff <= 11'd512) ? 14'd3816 : 14'd8424;
      r2      = {rem_ff[nr_tbs_pkg::DIV_W-1:0], quo_ff[nr_tbs_pkg::DIV_W-1]};
      plain   = ((nr_tbs_pkg::Q_W+1)'(q_ff) + (nr_tbs_pkg::Q_W+1)'(31)) &
                ~(nr_tbs_pkg::Q_W+1)'(7);
      plain   = plain - (nr_tbs_pkg::Q_W+1)'(24);
      seg_tbs = {ck_ff[25:0], 3'b000} - 29'd24;
   end

   always_comb begin
      blocks_in    = blocks_ff;
      qm_in        = qm_ff;
      rate_in      = rate_ff;
      layers_in    = layers_ff;
      prod_in      = prod_ff;
      mstep_in     = mstep_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      t_in         = t_ff;
      lg_in        = lg_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      dcnt_in      = dcnt_ff;
      c_in         = c_ff;
      ck_in        = ck_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         blocks_in = blk_sat;
         qm_in     = req_bits_per_symbol;
         rate_in   = req_rate_units;
         layers_in = req_layer_count;
         prod_in   = nr_tbs_pkg::PROD_W'(re);
         mstep_in  = 2'd0;
      end
      if (cmd.mul) begin
         prod_in  = nr_tbs_pkg::PROD_W'(prod_ff[30:0]) * nr_tbs_pkg::PROD_W'(mul_b);
         mstep_in = mstep_ff + 2'd1;
      end
      if (cmd.srch_init) begin
         lo_in = '0;
         hi_in = nr_tbs_pkg::IDX_W'(nr_tbs_pkg::TABLE_ENTRIES - 1);
      end
      if (cmd.srch_step) begin
         if (mid_val >= q_small) begin
            hi_in = mid;
         end else begin
            lo_in = mid + nr_tbs_pkg::IDX_W'(1);
         end
      end
      if (cmd.log_init) begin
         t_in  = dval;
         lg_in = '0;
      end
      if (cmd.log_step) begin
         t_in  = t_ff >> 1;
         lg_in = lg_ff + nr_tbs_pkg::LG_W'(1);
      end
      if (cmd.quant) begin
         q_in = q_round;
      end
      if (cmd.div1_start) begin
         quo_in  = nr_tbs_pkg::DIV_W'(q_ff) + nr_tbs_pkg::DIV_W'(23) + nr_tbs_pkg::DIV_W'(limit);
         dvs_in  = nr_tbs_pkg::DIV_W'(limit);
         rem_in  = '0;
         dcnt_in = nr_tbs_pkg::DCNT_W'(nr_tbs_pkg::DIV_STEPS);
      end
      if (cmd.div2_start) begin
         c_in    = quo_ff[nr_tbs_pkg::C_W-1:0];
         quo_in  = nr_tbs_pkg::DIV_W'(q_ff) + nr_tbs_pkg::DIV_W'(23) +
                   nr_tbs_pkg::DIV_W'({quo_ff[nr_tbs_pkg::C_W-1:0], 3'b000});
         dvs_in  = nr_tbs_pkg::DIV_W'({quo_ff[nr_tbs_pkg::C_W-1:0], 3'b000});
         rem_in  = '0;
         dcnt_in = nr_tbs_pkg::DCNT_W'(nr_tbs_pkg::DIV_STEPS);
      end
      if (cmd.div_step) begin
         if (r2 >= (nr_tbs_pkg::DIV_W+1)'(dvs_ff)) begin
            rem_in = r2 - (nr_tbs_pkg::DIV_W+1)'(dvs_ff);
            quo_in = {quo_ff[nr_tbs_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = r2;
            quo_in = {quo_ff[nr_tbs_pkg::DIV_W-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff - nr_tbs_pkg::DCNT_W'(1);
      end
      if (cmd.prod) begin
         ck_in = c_ff * quo_ff;
      end
      if (cmd.res_zero) begin
         res_in = '0;
      end
      if (cmd.res_small) begin
         res_in = 21'(nr_tbs_pkg::size_entry(lo_ff));
      end
      if (cmd.res_plain) begin
         res_in = (plain > (nr_tbs_pkg::Q_W+1)'(nr_tbs_pkg::OUT_MAX)) ?
                  nr_tbs_pkg::OUT_MAX : plain[20:0];
      end
      if (cmd.res_seg) begin
         res_in = (seg_tbs > 29'(nr_tbs_pkg::OUT_MAX)) ? nr_tbs_pkg::OUT_MAX : seg_tbs[20:0];
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         out_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mstep_ff     <= '0;
         dcnt_ff      <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         mstep_ff     <= mstep_in;
         dcnt_ff      <= dcnt_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
      end
      blocks_ff <= blocks_in;
      qm_ff     <= qm_in;
      rate_ff   <= rate_in;
      layers_ff <= layers_in;
      prod_ff   <= prod_in;
      t_ff      <= t_in;
      lg_ff     <= lg_in;
      q_ff      <= q_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      c_ff      <= c_in;
      ck_ff     <= ck_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

   always_comb begin
      st.mul_last  = (mstep_ff == 2'd3);
      st.zero      = (blocks_ff == 9'd0);
      st.fits_rom  = (ninfo <= nr_tbs_pkg::NINFO_W'(nr_tbs_pkg::SMALL_LIMIT));
      st.seg       = (rate_ff <= 11'd512) || (q_ff > nr_tbs_pkg::Q_W'(8424));
      st.log_done  = (t_ff <= nr_tbs_pkg::NINFO_W'(1));
      st.srch_done = (lo_ff == hi_ff);
      st.div_done  = (dcnt_ff == '0);
      st.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_block_size_bits = out_ff;

   `NR_TBS_ASSERT(a_div_load, clock, reset, (cmd.div1_start || cmd.div2_start) |=> (dcnt_ff == nr_tbs_pkg::DCNT_W'(nr_tbs_pkg::DIV_STEPS)), "divider count not loaded")
   `NR_TBS_ASSERT(a_rsp_rise, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.out_load), "result shown without load")
   `NR_TBS_NEVER(a_srch_order, clock, reset, lo_ff > hi_ff, "table search bounds crossed")

endmodule

### src/nr_tbs_ctrl.sv
// Controller of the transport block size unit: sequences the datapath.
// Depends on nr_tbs_pkg and the assertion macro header.
`include "nr_transport_block_size_unit_defines.svh"
module nr_tbs_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  nr_tbs_pkg::nr_tbs_status_type st,
   output nr_tbs_pkg::nr_tbs_cmd_type    cmd
);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_MUL    = 11'b00000000010,
      ST_BRANCH = 11'b00000000100,
      ST_SRCH   = 11'b00000001000,
      ST_LOG    = 11'b00000010000,
      ST_QUANT  = 11'b00000100000,
      ST_SEGCHK = 11'b00001000000,
      ST_DIV1   = 11'b00010000000,
      ST_DIV2   = 11'b00100000000,
      ST_PROD   = 11'b01000000000,
      ST_FIN    = 11'b10000000000
   } nr_tbs_state_type;

   nr_tbs_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            if (st.mul_last) begin
               state_in = ST_BRANCH;
            end
         end
         ST_BRANCH: begin
            if (st.zero) begin
               cmd.res_zero = 1'b1;
               state_in     = ST_FIN;
            end else if (st.fits_rom) begin
               cmd.srch_init = 1'b1;
               state_in      = ST_SRCH;
            end else begin
               cmd.log_init = 1'b1;
               state_in     = ST_LOG;
            end
         end
         ST_SRCH: begin
            if (st.srch_done) begin
               cmd.res_small = 1'b1;
               state_in      = ST_FIN;
            end else begin
               cmd.srch_step = 1'b1;
            end
         end
         ST_LOG: begin
            if (st.log_done) begin
               state_in = ST_QUANT;
            end else begin
               cmd.log_step = 1'b1;
            end
         end
         ST_QUANT: begin
            cmd.quant = 1'b1;
            state_in  = ST_SEGCHK;
         end
         ST_SEGCHK: begin
            if (st.seg) begin
               cmd.div1_start = 1'b1;
               state_in       = ST_DIV1;
            end else begin
               cmd.res_plain = 1'b1;
               state_in      = ST_FIN;
            end
         end
         ST_DIV1: begin
            if (st.div_done) begin
               cmd.div2_start = 1'b1;
               state_in       = ST_DIV2;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_DIV2: begin
            if (st.div_done) begin
               cmd.prod = 1'b1;
               state_in = ST_PROD;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_PROD: begin
            cmd.res_seg = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   `NR_TBS_ASSERT(a_take_to_mul, clock, reset, (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_MUL), "accepted transaction did not start")
   `NR_TBS_ASSERT(a_fin_hold, clock, reset, (state_ff == ST_FIN && !st.out_free) |=> (state_ff == ST_FIN), "result dropped while output busy")

endmodule

### src/nr_transport_block_size_unit.sv
// Transport block size unit (5G NR, one codeword): top level.
// Depends on nr_tbs_pkg, nr_tbs_ctrl and nr_tbs_datapath.
//
// Usage: present a request transaction on req_* with req_valid; it is taken
// when req_valid and req_ready are both high. req_ready is high only while
// the unit is between transactions. One result transaction per request
// appears on rsp_block_size_bits with rsp_valid, held until rsp_ready.
// Work from accepting edge to result valid, by case:
//   zero blocks                 : result set to zero directly
//   small sizes (Ninfo <= 3824) : binary search over the size table,
//                                 one probe per cycle, 6 or 7 probes
//   large, no segmentation      : leading-one search over Ninfo - 24
//                                 (the search steps one bit/cycle)
//   large, segmented            : as above, then two passes of the
//                                 shared 25-step divider
// One transaction is in work at a time. The result register frees the
// core: a new request is taken while the previous result still waits
// for rsp_ready. A finished result holds in res_ff, with the controller
// in ST_FIN, until the output register is free.
// Reset (synchronous, active high) drops any pending transaction and
// clears rsp_valid; the size table is constant logic and needs no fill.
module nr_transport_block_size_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [8:0]  req_num_blocks,
   input  logic [3:0]  req_symbols_per_slot,
   input  logic [3:0]  req_bits_per_symbol,
   input  logic [10:0] req_rate_units,
   input  logic [2:0]  req_layer_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_block_size_bits
);

   nr_tbs_pkg::nr_tbs_cmd_type    cmd;
   nr_tbs_pkg::nr_tbs_status_type st;

   // sequence the steps of one transaction
   nr_tbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   // hold operands, run the arithmetic and own the result register
   nr_tbs_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .st                   (st),
      .req_num_blocks       (req_num_blocks),
      .req_symbols_per_slot (req_symbols_per_slot),
      .req_bits_per_symbol  (req_bits_per_symbol),
      .req_rate_units       (req_rate_units),
      .req_layer_count      (req_layer_count),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_block_size_bits  (rsp_block_size_bits)
   );

endmodule

### verif/tb_nr_transport_block_size_unit.sv
// Self-checking testbench of the NR transport block size unit.
// Depends on nr_tbs_pkg and nr_transport_block_size_unit; computes expected sizes itself.
// Drives request transactions under several idle and stall patterns and checks every result.
module tb_nr_transport_block_size_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [8:0]  req_num_blocks;
   logic [3:0]  req_symbols_per_slot;
   logic [3:0]  req_bits_per_symbol;
   logic [10:0] req_rate_units;
   logic [2:0]  req_layer_count;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [20:0] rsp_block_size_bits;

   // Expected sizes, oldest first.
   logic [20:0] size_queue [$];
   int          error_count;
   int          cycle_count;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_off;

   nr_transport_block_size_unit DUT (.*);

   // Clock: 4 ns period.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Published small-size table, kept locally for the predictor.
   localparam logic [11:0] SIZE_TABLE [0:92] = '{
      24, 32, 40, 48, 56, 64, 72, 80, 88, 96, 104, 112, 120, 128, 136, 144,
      152, 160, 168, 176, 184, 192, 208, 224, 240, 256, 272, 288, 304, 320,
      336, 352, 368, 384, 408, 432, 456, 480, 504, 528, 552, 576, 608, 640,
      672, 704, 736, 768, 808, 848, 888, 928, 984, 1032, 1064, 1128, 1160,
      1192, 1224, 1256, 1288, 1320, 1352, 1416, 1480, 1544, 1608, 1672, 1736,
      1800, 1864, 1928, 2024, 2088, 2152, 2216, 2280, 2408, 2472, 2536, 2600,
      2664, 2728, 2792, 2856, 2976, 3104, 3240, 3368, 3496, 3624, 3752, 3824
   };

   function automatic int msb_index(input longint unsigned v);
      int r;
      r = 0;
      while (v > 1) begin
         v = v >> 1;
         r++;
      end
      return r;
   endfunction

   function automatic longint unsigned ceil_div(input longint unsigned a,
                                                input longint unsigned b);
      return (a + b - 1) / b;
   endfunction

   function automatic longint unsigned segment_size(input longint unsigned q,
                                                    input longint unsigned limit);
      longint unsigned c;
      c = ceil_div(q + 24, limit);
      return 8 * c * ceil_div(q + 24, 8 * c) - 24;
   endfunction

   // Transport block size predictor.
   function automatic logic [20:0] predict_size(input logic [8:0] blocks_in,
         input logic [3:0] symbols, input logic [3:0] qm, input logic [10:0] rate,
         input logic [2:0] layers);
      longint unsigned blocks, re_per_block, ninfo, q, d, tbs;
      int lg, n, j;
      if (blocks_in == 0) return '0;
      blocks = (blocks_in > nr_tbs_pkg::MAX_BLOCKS) ? nr_tbs_pkg::MAX_BLOCKS : blocks_in;
      re_per_block = 12 * symbols;
      if (re_per_block > 156) re_per_block = 156;
      ninfo = (re_per_block * blocks * rate * qm * layers) >> 11;
      if (ninfo <= 3824) begin
         lg = (ninfo == 0) ? 0 : msb_index(ninfo);
         n = (lg >= 9) ? lg - 6 : 3;
         q = (ninfo >> n) << n;
         if (q < 24) q = 24;
         for (j = 0; j < 92; j++) begin
            if (SIZE_TABLE[j] >= q) break;
         end
         tbs = SIZE_TABLE[j];
      end else begin
         d = ninfo - 24;
         n = msb_index(d) - 5;
         q = ((d + (64'd1 << (n - 1))) >> n) << n;
         if (q < 3840) q = 3840;
         if (rate <= 512) tbs = segment_size(q, 3816);
         else if (q > 8424) tbs = segment_size(q, 8424);
         else tbs = 8 * ceil_div(q + 24, 8) - 24;
      end
      if (tbs > nr_tbs_pkg::OUT_MAX) tbs = nr_tbs_pkg::OUT_MAX;
      return tbs[20:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [20:0] got,
                                  input logic [20:0] want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Send one request transaction; hold payload until accepted.
   task automatic send_request(input logic [8:0] nb, input logic [3:0] sy,
         input logic [3:0] qm, input logic [10:0] ru, input logic [2:0] ly);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_num_blocks <= nb;
      req_symbols_per_slot <= sy;
      req_bits_per_symbol <= qm;
      req_rate_units <= ru;
      req_layer_count <= ly;
      do @(posedge clock); while (!req_ready);
      size_queue.push_back(predict_size(nb, sy, qm, ru, ly));
   endtask

   // Random request: mostly legal ranges, a share of raw field values.
   task automatic send_random;
      logic [8:0] nb;
      int pick;
      pick = $urandom_range(9);
      if (pick < 6) nb = 9'($urandom_range(1, 40));
      else if (pick < 8) nb = 9'($urandom_range(0, 275));
      else nb = 9'($urandom);
      if (pick == 9) begin
         send_request(nb, 4'($urandom), 4'($urandom), 11'($urandom), 3'($urandom));
      end else begin
         send_request(nb, 4'($urandom_range(1, 14)), (pick < 5) ?
                      4'(2 * $urandom_range(0, 4)) | 4'(pick == 0) : 4'($urandom_range(1, 8)),
                      11'($urandom_range(1, 2047)), 3'($urandom_range(1, 4)));
      end
   endtask

   // Result checker and receiver-side stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (size_queue.size() == 0) begin
               report_mismatch("unexpected result", rsp_block_size_bits, '0);
            end else begin
               if (rsp_block_size_bits !== size_queue[0])
                  report_mismatch("block_size_bits", rsp_block_size_bits, size_queue[0]);
               void'(size_queue.pop_front());
            end
         end
         rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic wait_drained;
      req_valid <= 1'b0;
      while (size_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed;
      send_request(0, 14, 8, 2047, 4);
      send_request(1, 1, 1, 1, 1);
      send_request(275, 14, 8, 2047, 4);
      send_request(511, 15, 15, 2047, 7);
      send_request(300, 14, 6, 900, 2);
      send_request(10, 0, 2, 500, 1);
      send_request(10, 4, 0, 500, 1);
      send_request(10, 4, 2, 0, 1);
      send_request(10, 4, 2, 500, 0);
      send_request(2, 14, 3, 1000, 1);
      send_request(20, 14, 2, 512, 1);
      send_request(20, 14, 2, 513, 1);
      send_request(100, 14, 2, 512, 2);
      send_request(30, 12, 2, 1024, 1);
      send_request(40, 13, 4, 800, 1);
      send_request(50, 14, 6, 1500, 2);
      send_request(8, 14, 4, 600, 1);
      send_request(3, 10, 2, 700, 1);
      send_request(256, 8, 5, 1234, 3);
      send_request(1, 14, 8, 2047, 4);
      wait_drained();
   endtask

   task automatic test_random_phase(input int send_pct, input int recv_pct, input int count);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) send_random();
   endtask

   // Hold off the receiver while requests pile up and the input stalls.
   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         repeat (10) send_random();
      join
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_num_blocks = '0;
      req_symbols_per_slot = '0;
      req_bits_per_symbol = '0;
      req_rate_units = '0;
      req_layer_count = '0;
      error_count = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(0, 0, 250);
      test_random_phase(56, 0, 250);
      wait_drained();
      test_backpressure();
      test_random_phase(0, 56, 250);
      test_random_phase(37, 37, 250);
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

### sim.f
+incdir+src
src/nr_tbs_pkg.sv
src/nr_tbs_datapath.sv
src/nr_tbs_ctrl.sv
src/nr_transport_block_size_unit.sv
verif/tb_nr_transport_block_size_unit.sv
